// ----- rtl/rkeg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkeg_pkg
// shared constants, types and the scan-code translation rom
// ----------------------------------------------------------------------------
package rkeg_pkg;

  localparam int KEY_SLOTS  = 3;
  localparam int CODE_W     = 8;
  localparam int KEY_W      = 7;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_RELEASE = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_SYNC    = 2'd2
  } rkeg_kind_t;

  typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] rkeg_codes_t;

  // one classified tick
  typedef struct packed {
    logic [KEY_SLOTS-1:0] rel;
    logic [KEY_SLOTS-1:0] prs;
    rkeg_codes_t          prev_code;
    rkeg_codes_t          cur_code;
  } rkeg_rec_t;

  function automatic logic [KEY_W-1:0] rkeg_key_rom(input logic [CODE_W-1:0] code);
    logic [KEY_W-1:0] rom;
    case (code)
      8'd6:   rom = 7'd102;  8'd7:   rom = 7'd107;  8'd8:   rom = 7'd104;
      8'd9:   rom = 7'd109;  8'd10:  rom = 7'd70;
      8'd16:  rom = 7'd30;   8'd17:  rom = 7'd48;   8'd18:  rom = 7'd46;
      8'd19:  rom = 7'd32;   8'd20:  rom = 7'd18;   8'd21:  rom = 7'd33;
      8'd22:  rom = 7'd34;   8'd23:  rom = 7'd35;   8'd24:  rom = 7'd23;
      8'd25:  rom = 7'd36;   8'd26:  rom = 7'd37;   8'd27:  rom = 7'd38;
      8'd28:  rom = 7'd50;   8'd29:  rom = 7'd49;   8'd30:  rom = 7'd24;
      8'd31:  rom = 7'd25;
      8'd32:  rom = 7'd16;   8'd33:  rom = 7'd19;   8'd34:  rom = 7'd31;
      8'd35:  rom = 7'd20;   8'd36:  rom = 7'd22;   8'd37:  rom = 7'd47;
      8'd38:  rom = 7'd17;   8'd39:  rom = 7'd45;   8'd40:  rom = 7'd21;
      8'd41:  rom = 7'd44;   8'd42:  rom = 7'd2;    8'd43:  rom = 7'd3;
      8'd44:  rom = 7'd4;    8'd45:  rom = 7'd5;    8'd46:  rom = 7'd6;
      8'd47:  rom = 7'd7;
      8'd48:  rom = 7'd8;    8'd49:  rom = 7'd9;    8'd50:  rom = 7'd10;
      8'd51:  rom = 7'd11;   8'd52:  rom = 7'd12;   8'd53:  rom = 7'd13;
      8'd54:  rom = 7'd43;   8'd55:  rom = 7'd40;   8'd56:  rom = 7'd26;
      8'd57:  rom = 7'd39;   8'd58:  rom = 7'd40;   8'd59:  rom = 7'd27;
      8'd60:  rom = 7'd51;   8'd61:  rom = 7'd52;   8'd62:  rom = 7'd53;
      8'd63:  rom = 7'd43;
      8'd64:  rom = 7'd59;   8'd65:  rom = 7'd60;   8'd66:  rom = 7'd61;
      8'd67:  rom = 7'd62;   8'd68:  rom = 7'd63;   8'd69:  rom = 7'd64;
      8'd70:  rom = 7'd65;   8'd71:  rom = 7'd66;   8'd72:  rom = 7'd67;
      8'd73:  rom = 7'd68;   8'd74:  rom = 7'd87;   8'd75:  rom = 7'd88;
      8'd76:  rom = 7'd1;    8'd77:  rom = 7'd110;  8'd78:  rom = 7'd111;
      8'd79:  rom = 7'd41;
      8'd80:  rom = 7'd14;   8'd81:  rom = 7'd15;   8'd83:  rom = 7'd58;
      8'd84:  rom = 7'd42;   8'd85:  rom = 7'd54;   8'd86:  rom = 7'd29;
      8'd87:  rom = 7'd56;   8'd89:  rom = 7'd57;   8'd92:  rom = 7'd105;
      8'd93:  rom = 7'd108;  8'd94:  rom = 7'd103;  8'd95:  rom = 7'd106;
      8'd97:  rom = 7'd28;   8'd100: rom = 7'd39;   8'd101: rom = 7'd78;
      8'd106: rom = 7'd69;
      8'd171: rom = 7'd69;   8'd174: rom = 7'd70;
      default: rom = '0;
    endcase
    return rom;
  endfunction

endpackage

// ----- rtl/rkeg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkeg_front
// accepts a tick, finds released and pressed slots, keeps the previous codes
// ----------------------------------------------------------------------------
module rkeg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rkeg_pkg::rkeg_codes_t in_codes,
  input  logic                q_full,
  output logic                q_push,
  output rkeg_pkg::rkeg_rec_t q_rec
);
  import rkeg_pkg::*;

  rkeg_codes_t prev_r;
  rkeg_codes_t prev_nxt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign prev_nxt = q_push ? in_codes : prev_r;

  always_comb begin
    logic held;
    q_rec.prev_code = prev_r;
    q_rec.cur_code  = in_codes;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      held = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (in_codes[j] == prev_r[i]) begin
          held = 1'b1;
        end
      end
      q_rec.rel[i] = (prev_r[i] != '0) && !held;
      q_rec.prs[i] = (in_codes[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

// ----- rtl/rkeg_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkeg_queue
// short fifo of classified ticks between front and back
// ----------------------------------------------------------------------------
module rkeg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rkeg_pkg::rkeg_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output rkeg_pkg::rkeg_rec_t head_rec
);
  import rkeg_pkg::*;

  rkeg_rec_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ----- rtl/rkeg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkeg_back
// walks one tick: releases, then presses, then sync, through an output register
// ----------------------------------------------------------------------------
module rkeg_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  rkeg_pkg::rkeg_rec_t  q_rec,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [rkeg_pkg::KEY_W-1:0] out_code,
  output rkeg_pkg::rkeg_kind_t out_kind,
  output logic                 out_last
);
  import rkeg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [KEY_SLOTS-1:0] rel_r, rel_nxt;
  logic [KEY_SLOTS-1:0] prs_r, prs_nxt;
  rkeg_codes_t          prev_code_r, prev_code_nxt;
  rkeg_codes_t          cur_code_r, cur_code_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]     out_code_r, out_code_nxt;
  rkeg_kind_t           out_kind_r, out_kind_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 advance, emit, last_ev, load, rel_any, prs_any;
  logic [KEY_SLOTS-1:0] rel_first, prs_first;
  logic [CODE_W-1:0]    ev_code;
  rkeg_kind_t           ev_kind;

  assign rel_any   = |rel_r;
  assign prs_any   = |prs_r;
  assign rel_first = rel_r & (~rel_r + 1'b1);
  assign prs_first = rel_any ? '0 : (prs_r & (~prs_r + 1'b1));
  assign advance   = !out_valid_r || out_ready;
  assign emit      = busy_r && advance;
  assign last_ev   = emit && !rel_any && !prs_any;
  assign load      = (!busy_r || last_ev) && q_valid;
  assign q_pop     = load;

  always_comb begin
    ev_code = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      ev_code = ev_code | ({CODE_W{rel_first[i]}} & prev_code_r[i])
                        | ({CODE_W{prs_first[i]}} & cur_code_r[i]);
    end
    priority if (rel_any) begin
      ev_kind = KIND_RELEASE;
    end else if (prs_any) begin
      ev_kind = KIND_PRESS;
    end else begin
      ev_kind = KIND_SYNC;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    rel_nxt       = rel_r;
    prs_nxt       = prs_r;
    prev_code_nxt = prev_code_r;
    cur_code_nxt  = cur_code_r;
    if (emit) begin
      rel_nxt = rel_r & ~rel_first;
      prs_nxt = prs_r & ~prs_first;
    end
    if (last_ev) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt      = 1'b1;
      rel_nxt       = q_rec.rel;
      prs_nxt       = q_rec.prs;
      prev_code_nxt = q_rec.prev_code;
      cur_code_nxt  = q_rec.cur_code;
    end
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_code_nxt  = emit ? rkeg_key_rom(ev_code) : out_code_r;
    out_kind_nxt  = emit ? ev_kind : out_kind_r;
    out_last_nxt  = emit ? (ev_kind == KIND_SYNC) : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_r       <= rel_nxt;
    prs_r       <= prs_nxt;
    prev_code_r <= prev_code_nxt;
    cur_code_r  <= cur_code_nxt;
    out_code_r  <= out_code_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/rollover_key_event_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rollover_key_event_generator
// turns polled rollover scan-code reports into release/press/sync key events
// ----------------------------------------------------------------------------
// input channel: one request per poll tick carrying three scan-code slots
// (0 = empty). output channel: a run of key events per request, releases of
// keys gone since the last tick in slot order, then a press for every
// occupied slot in slot order, then a sync event with tlast set.
// with the queue empty, an accepted tick is written to the queue, loaded into
// the sequencer registers, and its first event then leaves from the output
// register. a tick with r releases and p presses gives r + p + 1 events
// (1 to 7) on the single output port. a 2-entry tick queue sits between the
// classifier and the event sequencer, so ticks are accepted back to back
// while earlier ticks are still being emitted, until the queue fills.
// reset clears the previous-code store to all empty, the queue and the
// output valid flag. while the receiver stalls, the output register holds its
// event, the sequencer waits, and in_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module rollover_key_event_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // slot_a_code, slot_b_code, slot_c_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // key_code, zero pad
  output logic [1:0]  out_tuser,  // event_kind
  output logic        out_tlast
);
  import rkeg_pkg::*;

  rkeg_codes_t      in_codes;
  rkeg_rec_t        push_rec, head_rec;
  logic             q_push, q_full, q_pop, q_valid;
  logic [KEY_W-1:0] out_code;
  rkeg_kind_t       out_kind;

  always_comb begin
    in_codes = '0;
    in_codes[0] = in_tdata[7:0];
    if (KEY_SLOTS > 1) in_codes[1] = in_tdata[15:8];
    if (KEY_SLOTS > 2) in_codes[2] = in_tdata[23:16];
  end

  rkeg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_codes (in_codes),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  rkeg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_rec   (head_rec)
  );

  rkeg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rec     (head_rec),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (out_code),
    .out_kind  (out_kind),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, out_code};
  assign out_tuser = out_kind;

endmodule

// ----- rtl/rkeg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkeg_checker
// port-level checks on the key event stream
// ----------------------------------------------------------------------------
module rkeg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import rkeg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled event changed");

  a_last_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == KIND_SYNC)))
    else $error("tlast does not match sync kind");

  a_sync_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SYNC |-> out_tdata == '0)
    else $error("sync event with nonzero key code");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_RELEASE || out_tuser == KIND_PRESS ||
      out_tuser == KIND_SYNC) && !out_tdata[7])
    else $error("bad event kind or key code pad");

endmodule

bind rollover_key_event_generator rkeg_checker u_rkeg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
